// File: hdl/scgov_pkg.sv
// Shared types, constants and frequency tables for the stepwise frequency governor.
// No dependencies; every other file in the project uses this package.
`default_nettype none

package scgov_pkg;

   // Field widths
   localparam int KHZ_W  = 22;
   localparam int LOAD_W = 7;
   localparam int CNT_W  = 4;
   localparam int LVL_W  = 5;   // level index, tables hold at most 32 levels
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Frequency tables and the number of levels in use per cluster
   localparam int LITTLE_TABLE_SIZE = 12;
   localparam int BIG_TABLE_SIZE    = 18;
   localparam int LITTLE_LEVELS     = 12;
   localparam int BIG_LEVELS        = 18;
   localparam int LITTLE_USED = (LITTLE_LEVELS < LITTLE_TABLE_SIZE) ?
                                LITTLE_LEVELS : LITTLE_TABLE_SIZE;
   localparam int BIG_USED    = (BIG_LEVELS < BIG_TABLE_SIZE) ?
                                BIG_LEVELS : BIG_TABLE_SIZE;

   typedef logic [KHZ_W-1:0]  khz_type;
   typedef logic [LVL_W-1:0]  lvl_type;
   typedef logic [LOAD_W-1:0] load_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   localparam khz_type LITTLE_KHZ [2**LVL_W] = '{
      0: 22'd455000,  1: 22'd598000,  2: 22'd715000,  3: 22'd832000,
      4: 22'd949000,  5: 22'd1053000, 6: 22'd1248000, 7: 22'd1456000,
      8: 22'd1690000, 9: 22'd1794000, 10: 22'd1898000, 11: 22'd2002000,
      default: 22'd0
   };

   localparam khz_type BIG_KHZ [2**LVL_W] = '{
      0: 22'd741000,   1: 22'd858000,   2: 22'd962000,   3: 22'd1066000,
      4: 22'd1170000,  5: 22'd1261000,  6: 22'd1469000,  7: 22'd1703000,
      8: 22'd1807000,  9: 22'd1937000,  10: 22'd2002000, 11: 22'd2158000,
      12: 22'd2314000, 13: 22'd2496000, 14: 22'd2574000, 15: 22'd2652000,
      16: 22'd2704000, 17: 22'd2808000,
      default: 22'd0
   };

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RAISE_PCT    = 2'd0,
      CSR_DOWN_FACTOR  = 2'd1,
      CSR_BOOST_MODE   = 2'd2
   } csr_idx_type;

   localparam load_type RAISE_PCT_RESET    = 7'd75;
   localparam cnt_type  DOWN_FACTOR_RESET  = 4'd2;
   localparam logic     BOOST_MODE_RESET   = 1'b1;

   // Down threshold = floor(up * 455/598) - 25. 455/598 reduces to 35/46;
   // floor(y/46) for y < 4446 is (y * 1425) >> 16, folded into one constant.
   localparam int DOWN_MARGIN = 25;
   localparam int RATIO_MULT  = 35 * 1425;
   localparam int RATIO_SHIFT = 16;
   localparam int RATIO_PROD_W = LOAD_W + RATIO_SHIFT;

   // Configuration handed from the register block to the datapath
   typedef struct packed {
      load_type raise_pct;
      cnt_type  down_factor;
      logic     boost_mode;
      load_type down_quot;   // down threshold plus DOWN_MARGIN, never negative
   } cfg_type;

   // One request as held in the input register
   typedef struct packed {
      logic     cluster;
      load_type load_percent;
      khz_type  cur_khz;
      khz_type  min_khz;
      khz_type  max_khz;
   } req_type;

   // Decision for one request plus the updated skip counter
   typedef struct packed {
      logic    request_valid;
      khz_type target_khz;
      logic    relation;
      cnt_type skip_next;
   } decision_type;

   function automatic load_type down_quot(input load_type up);
      logic [RATIO_PROD_W-1:0] prod;
      prod = RATIO_PROD_W'(up) * RATIO_PROD_W'(RATIO_MULT);
      return prod[RATIO_PROD_W-1:RATIO_SHIFT];
   endfunction

   function automatic khz_type level_khz(input logic cl, input lvl_type idx);
      return cl ? BIG_KHZ[idx] : LITTLE_KHZ[idx];
   endfunction

endpackage

`default_nettype wire

// File: hdl/scgov_ifs.sv
// Handshake channel interfaces: load sample requests, frequency responses and
// register writes. Depends on scgov_pkg for field types.
`default_nettype none

interface scgov_req_if;
   logic                 valid;
   logic                 ready;
   logic                 cluster;
   scgov_pkg::load_type  load_percent;
   scgov_pkg::khz_type   cur_khz;
   scgov_pkg::khz_type   min_khz;
   scgov_pkg::khz_type   max_khz;

   modport source (output valid, cluster, load_percent, cur_khz, min_khz, max_khz,
                   input ready);
   modport sink   (input valid, cluster, load_percent, cur_khz, min_khz, max_khz,
                   output ready);
endinterface

interface scgov_rsp_if;
   logic                valid;
   logic                ready;
   logic                request_valid;
   scgov_pkg::khz_type  target_khz;
   logic                relation;

   modport source (output valid, request_valid, target_khz, relation, input ready);
   modport sink   (input valid, request_valid, target_khz, relation, output ready);
endinterface

interface scgov_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [scgov_pkg::CSR_IDX_W-1:0]      index;
   logic [scgov_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/scgov_csr.sv
// Configuration registers of the governor and the derived down threshold.
// Depends on scgov_pkg and scgov_csr_if.
`default_nettype none

module scgov_csr (
   input  wire logic          clock,
   input  wire logic          reset,
   scgov_csr_if.sink          csr_if,
   output scgov_pkg::cfg_type cfg
);
   import scgov_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken
   assign csr_if.ready = 1'b1;

   // Register update; the down threshold is recomputed when the raise threshold changes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_RAISE_PCT: begin
               cfg_in.raise_pct = csr_if.data[LOAD_W-1:0];
               cfg_in.down_quot = down_quot(csr_if.data[LOAD_W-1:0]);
            end
            CSR_DOWN_FACTOR: cfg_in.down_factor = csr_if.data[CNT_W-1:0];
            CSR_BOOST_MODE:  cfg_in.boost_mode  = csr_if.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raise_pct    <= RAISE_PCT_RESET;
         cfg_ff.down_factor  <= DOWN_FACTOR_RESET;
         cfg_ff.boost_mode   <= BOOST_MODE_RESET;
         cfg_ff.down_quot    <= down_quot(RAISE_PCT_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hdl/scgov_decide.sv
// Single-pass decision logic: table lookup, up/down step choice and the
// skip counter update for one load sample. Depends on scgov_pkg.
`default_nettype none

module scgov_decide (
   input  wire scgov_pkg::cfg_type      cfg,
   input  wire scgov_pkg::req_type      req,
   input  wire scgov_pkg::cnt_type      skip_cur,
   output scgov_pkg::decision_type      dec
);
   import scgov_pkg::*;

   logic [LVL_W:0]  n_used;
   logic            hit;
   lvl_type         lv;
   khz_type         next_khz;
   khz_type         prev_khz;
   logic [CNT_W:0]  cnt_inc;
   logic [LOAD_W:0] load_margin;

   // Find the current frequency among the levels in use (tables are strictly
   // increasing, so at most one level matches)
   always_comb begin
      n_used = req.cluster ? (LVL_W+1)'(BIG_USED) : (LVL_W+1)'(LITTLE_USED);
      hit = 1'b0;
      lv  = '0;
      for (int i = 0; i < 2**LVL_W; i++) begin
         if ((LVL_W+1)'(i) < n_used &&
             level_khz(req.cluster, LVL_W'(i)) == req.cur_khz) begin
            hit = 1'b1;
            lv  = lv | LVL_W'(i);
         end
      end
   end

   // Neighbor levels; only used where the index is known to be in range
   assign next_khz = level_khz(req.cluster, lv + LVL_W'(1));
   assign prev_khz = level_khz(req.cluster, lv - LVL_W'(1));

   assign cnt_inc     = {1'b0, skip_cur} + (CNT_W+1)'(1);
   assign load_margin = {1'b0, req.load_percent} + (LOAD_W+1)'(DOWN_MARGIN);

   always_comb begin
      dec.request_valid = 1'b0;
      dec.target_khz    = '0;
      dec.relation      = 1'b0;
      dec.skip_next     = skip_cur;

      if (req.load_percent >= cfg.raise_pct) begin
         // High load: clear the counter and go up
         dec.skip_next = '0;
         if (req.cur_khz != req.max_khz) begin
            if (!cfg.boost_mode) begin
               if (hit && ({1'b0, lv} + (LVL_W+1)'(1)) < n_used) begin
                  dec.request_valid = 1'b1;
                  dec.target_khz = (next_khz > req.max_khz) ? req.max_khz : next_khz;
               end
            end else if (!req.cluster && hit && lv == '0) begin
               // little cluster at its lowest level takes one step only
               dec.request_valid = 1'b1;
               dec.target_khz = (next_khz > req.max_khz) ? req.max_khz : next_khz;
            end else begin
               dec.request_valid = 1'b1;
               dec.target_khz    = req.max_khz;
            end
         end
      end else if (req.cur_khz != req.min_khz) begin
         // Low load: count samples, consider a step down every down_factor
         if (cnt_inc < {1'b0, cfg.down_factor}) begin
            dec.skip_next = cnt_inc[CNT_W-1:0];
         end else begin
            dec.skip_next = '0;
            if (load_margin <= {1'b0, cfg.down_quot} && hit && lv != '0) begin
               dec.request_valid = 1'b1;
               dec.relation      = 1'b1;
               dec.target_khz = (prev_khz < req.min_khz) ? req.min_khz : prev_khz;
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: hdl/stepwise_cpu_frequency_governor.sv
// Top level of the stepwise two-cluster frequency governor: input register,
// per-cluster skip counters and response register.
// Depends on scgov_pkg, scgov_ifs, scgov_csr and scgov_decide.
//
//   channel | port   | direction | carries
//   --------+--------+-----------+---------------------------------------------
//   request | req_if | in        | cluster, load_percent, cur/min/max_khz
//   result  | rsp_if | out       | request_valid, target_khz, relation
//   config  | csr_if | in        | register index, write data
//
// One request per cycle sustained while rsp ready is high. A request waits in the
// input register until the response register takes it (one pass of lookup and
// decision logic between them). Skip counters update as requests leave the input
// register, so back-to-back samples of one cluster see each other's counts.
// A stalled response drops req ready only once the input register is full too.
// Synchronous reset clears valid flags and skip counters, sets config defaults.
`default_nettype none

module stepwise_cpu_frequency_governor (
   input  wire logic   clock,
   input  wire logic   reset,
   scgov_req_if.sink   req_if,
   scgov_rsp_if.source rsp_if,
   scgov_csr_if.sink   csr_if
);
   import scgov_pkg::*;

   cfg_type      cfg;
   decision_type dec;

   logic    a_valid_ff;
   req_type a_req_ff;
   logic    advance;

   cnt_type skip_ff [2];

   logic    rsp_valid_ff;
   logic    request_valid_ff;
   khz_type target_khz_ff;
   logic    relation_ff;

   scgov_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   scgov_decide u_decide (
      .cfg      (cfg),
      .req      (a_req_ff),
      .skip_cur (skip_ff[a_req_ff.cluster]),
      .dec      (dec)
   );

   // Handshake: input stage moves on when the response register is free
   assign advance      = a_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !a_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         a_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         a_req_ff.cluster      <= req_if.cluster;
         a_req_ff.load_percent <= req_if.load_percent;
         a_req_ff.cur_khz      <= req_if.cur_khz;
         a_req_ff.min_khz      <= req_if.min_khz;
         a_req_ff.max_khz      <= req_if.max_khz;
      end
   end

   // Per-cluster down-skip counters
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff[0] <= '0;
         skip_ff[1] <= '0;
      end else if (advance) begin
         skip_ff[a_req_ff.cluster] <= dec.skip_next;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_if.ready) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         request_valid_ff <= dec.request_valid;
         target_khz_ff    <= dec.target_khz;
         relation_ff      <= dec.relation;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.request_valid = request_valid_ff;
   assign rsp_if.target_khz    = target_khz_ff;
   assign rsp_if.relation      = relation_ff;

endmodule

`default_nettype wire
